// ===== src/pwg_pkg.sv =====
// package for the periodic waveform generator: widths, register and waveform codes,
// divider command and status structs, and the quarter-wave sine table built at elaboration
// no dependencies
package pwg_pkg;

   // tone limits and sine resolution
   localparam int unsigned MIN_TONE_HZ     = 20;
   localparam int unsigned SINE_PHASE_BITS = 10;
   localparam int unsigned QUARTER_BITS    = SINE_PHASE_BITS - 2;
   localparam int unsigned QUARTER_SIZE    = 1 << QUARTER_BITS;

   // field and register widths
   localparam int unsigned WAVE_WIDTH   = 2;
   localparam int unsigned RATE_WIDTH   = 18;
   localparam int unsigned FREQ_WIDTH   = 17;
   localparam int unsigned SAMPLE_WIDTH = 8;
   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // shared divider sizing
   localparam int unsigned DIV_WIDTH   = 18;
   localparam int unsigned COUNT_WIDTH = 5;
   localparam logic [COUNT_WIDTH-1:0] PERIOD_STEPS = COUNT_WIDTH'(RATE_WIDTH);
   localparam logic [COUNT_WIDTH-1:0] SINE_STEPS   = COUNT_WIDTH'(SINE_PHASE_BITS + 1);
   localparam logic [COUNT_WIDTH-1:0] RAMP_STEPS   = COUNT_WIDTH'(SAMPLE_WIDTH + 1);

   // register indexes
   localparam logic [1:0] REG_WAVEFORM    = 2'd0;
   localparam logic [1:0] REG_SAMPLE_RATE = 2'd1;
   localparam logic [1:0] REG_TONE_FREQ   = 2'd2;

   // waveform codes
   localparam logic [WAVE_WIDTH-1:0] WAVE_SINE     = 2'd0;
   localparam logic [WAVE_WIDTH-1:0] WAVE_SQUARE   = 2'd1;
   localparam logic [WAVE_WIDTH-1:0] WAVE_TRIANGLE = 2'd2;
   localparam logic [WAVE_WIDTH-1:0] WAVE_SAW      = 2'd3;

   // sample levels
   localparam logic [SAMPLE_WIDTH-1:0] BIAS_VAL = 8'h80;
   localparam logic [SAMPLE_WIDTH-1:0] FULL_VAL = 8'hFF;

   localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

   // command into the shared divider
   typedef struct packed {
      logic                   start;
      logic [DIV_WIDTH-1:0]   rem;
      logic [DIV_WIDTH-1:0]   dvd;
      logic [DIV_WIDTH-1:0]   dvsr;
      logic [COUNT_WIDTH-1:0] steps;
   } div_cmd_type;

   // status back from the shared divider
   typedef struct packed {
      logic                 done;
      logic [DIV_WIDTH-1:0] quotient;
   } div_sts_type;

   // each entry: ceiling in the upper byte, floor in the lower byte, of 128*sin
   typedef logic [QUARTER_SIZE-1:0][15:0] qsine_table_type;

   // (a*b) >> 60, elaboration use only
   function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[123:60];
   endfunction

   // shift and subtract quotient of two 64-bit values, elaboration use only
   function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      int unsigned b;
      rem = '0;
      quo = '0;
      for (b = 0; b < 64; b++) begin
         rem = {rem[63:0], num[63 - b]};
         if (rem >= {1'b0, den}) begin
            rem         = rem - {1'b0, den};
            quo[63 - b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // taylor series for sin(pi/2 * k / QUARTER_SIZE) in q60
   function automatic logic [63:0] quarter_sine(int unsigned k);
      logic [63:0] frac;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] fact;
      int unsigned j;
      frac = 64'(k) << (60 - QUARTER_BITS);
      x    = mul_q60(HALF_PI_Q60, frac);
      x2   = mul_q60(x, x);
      term = x;
      sum  = x;
      for (j = 1; j < 16; j++) begin
         fact = 64'((2 * j) * (2 * j + 1));
         term = div_u64(mul_q60(term, x2), fact);
         if (j[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   // floor and ceiling of the quarter sine scaled to 128
   function automatic logic [15:0] qsine_entry(int unsigned k);
      logic [63:0] s;
      logic [63:0] lo;
      logic [63:0] hi;
      s  = quarter_sine(k);
      lo = s >> 53;
      hi = (s + ((64'd1 << 53) - 64'd1)) >> 53;
      return {hi[7:0], lo[7:0]};
   endfunction

   function automatic qsine_table_type build_qsine();
      qsine_table_type tbl;
      int unsigned k;
      for (k = 0; k < QUARTER_SIZE; k++) begin
         tbl[k] = qsine_entry(k);
      end
      return tbl;
   endfunction

   localparam qsine_table_type QSINE_TABLE = build_qsine();
   localparam logic [15:0]     QSINE_PEAK  = qsine_entry(QUARTER_SIZE);

endpackage

// ===== src/pwg_if.sv =====
// valid/ready channel interfaces for the sample tick requests and the sample results
// depends on nothing; payload widths match pwg_pkg field widths
interface pwg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface pwg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample;
   logic       period_end;
   logic       active;

   modport source (output valid, output sample, output period_end, output active,
                   input ready);
   modport sink (input valid, input sample, input period_end, input active,
                 output ready);
endinterface

// ===== src/periodic_waveform_generator.sv =====
// top level of the periodic waveform generator: registers, sequencer and sample shaping
// depends on pwg_pkg, the channel interfaces in pwg_if and the shared divider pwg_divider
//
// usage
// - req_bus carries one sample tick per transfer; restart high starts a new period at index 0
// - rsp_bus returns one transfer per tick: sample (bias 128), period_end and active
// - the apb port holds waveform (0x0), sample rate (0x4) and tone frequency (0x8); any
//   write to these moves the next sample back to index 0; write only while no tick is open
// - each tick first divides sample rate by tone frequency, then runs a
//   second division for the phase or ramp level (sine, triangle and saw; none for square)
// - when the settings are out of range both divisions are skipped (result 128, inactive)
// - one tick is in work at a time, and req_bus.ready is high only while idle, so a new
//   tick on req_bus is taken only once the sequencer is through with the last one
// - the result sits in an output register, so a new tick is taken while it waits; a stalled
//   receiver holds the next result in the final sequencer step
// - reset clears the registers, the sample index and the channels; no clearing pass
module periodic_waveform_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   pwg_req_if.sink                              req_bus,
   pwg_rsp_if.source                            rsp_bus,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [pwg_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [pwg_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [pwg_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                 pready
);

   localparam int unsigned RW = pwg_pkg::RATE_WIDTH;
   localparam int unsigned FW = pwg_pkg::FREQ_WIDTH;
   localparam int unsigned SW = pwg_pkg::SAMPLE_WIDTH;
   localparam int unsigned PB = pwg_pkg::SINE_PHASE_BITS;
   localparam int unsigned QB = pwg_pkg::QUARTER_BITS;
   localparam int unsigned KW = QB + 1;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV_N  = 3'd1;
   localparam logic [2:0] ST_INDEX  = 3'd2;
   localparam logic [2:0] ST_SETUP  = 3'd3;
   localparam logic [2:0] ST_DIV_W  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [pwg_pkg::WAVE_WIDTH-1:0] waveform_ff, waveform_in;
   logic [RW-1:0]                  sample_rate_ff, sample_rate_in;
   logic [FW-1:0]                  tone_freq_ff, tone_freq_in;
   logic [RW-1:0]                  idx_ff, idx_in;
   logic [RW-1:0]                  n_ff, n_in;
   logic [RW-1:0]                  i_ff, i_in;
   logic                           restart_ff, restart_in;
   logic                           lower_ff, lower_in;
   logic                           live_ff, live_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]                  sample_ff, sample_in;
   logic                           period_end_ff, period_end_in;
   logic                           active_ff, active_in;

   pwg_pkg::div_cmd_type div_cmd;
   pwg_pkg::div_sts_type div_sts;

   logic          cfg_write;
   logic          cfg_hit;
   logic [1:0]    cfg_index;
   logic          cfg_ok;
   logic          req_take;
   logic          out_free;
   logic          load_out;
   logic [RW-1:0] half;
   logic          lower_now;
   logic [RW-1:0] ramp_x;

   logic [PB-1:0]  phase;
   logic [1:0]     quad;
   logic [QB-1:0]  qpos;
   logic [KW-1:0]  kpos;
   logic [15:0]    qentry;
   logic [SW-1:0]  qfloor;
   logic [SW-1:0]  qceil;
   logic [SW:0]    pos_sum;
   logic [SW-1:0]  sine_v;
   logic [SW-1:0]  wave_v;
   logic           last_now;

   // shared divider
   pwg_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   // apb decode
   assign pready    = 1'b1;
   assign cfg_index = paddr[3:2];
   assign cfg_write = psel && penable && pwrite;
   assign cfg_hit   = cfg_write && (cfg_index == pwg_pkg::REG_WAVEFORM ||
                                    cfg_index == pwg_pkg::REG_SAMPLE_RATE ||
                                    cfg_index == pwg_pkg::REG_TONE_FREQ);

   always_comb begin
      unique case (cfg_index)
         pwg_pkg::REG_WAVEFORM:    prdata = pwg_pkg::CSR_DATA_WIDTH'(waveform_ff);
         pwg_pkg::REG_SAMPLE_RATE: prdata = pwg_pkg::CSR_DATA_WIDTH'(sample_rate_ff);
         pwg_pkg::REG_TONE_FREQ:   prdata = pwg_pkg::CSR_DATA_WIDTH'(tone_freq_ff);
         default:                  prdata = '0;
      endcase
   end

   // register writes
   always_comb begin
      waveform_in    = waveform_ff;
      sample_rate_in = sample_rate_ff;
      tone_freq_in   = tone_freq_ff;
      if (cfg_write) begin
         unique case (cfg_index)
            pwg_pkg::REG_WAVEFORM:    waveform_in    = pwdata[pwg_pkg::WAVE_WIDTH-1:0];
            pwg_pkg::REG_SAMPLE_RATE: sample_rate_in = pwdata[RW-1:0];
            pwg_pkg::REG_TONE_FREQ:   tone_freq_in   = pwdata[FW-1:0];
            default: ;
         endcase
      end
   end

   // settings in range
   assign cfg_ok = (sample_rate_ff >= RW'(2 * pwg_pkg::MIN_TONE_HZ)) &&
                   (tone_freq_ff >= FW'(pwg_pkg::MIN_TONE_HZ)) &&
                   ({1'b0, tone_freq_ff} <= (sample_rate_ff >> 1));

   // handshakes
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign load_out      = (state_ff == ST_FINISH) && out_free;

   // half period and ramp numerator
   assign half      = n_ff >> 1;
   assign lower_now = i_ff < half;
   assign ramp_x    = lower_now ? i_ff : i_ff - half;

   // quarter-wave sine lookup
   assign phase  = div_sts.quotient[PB-1:0];
   assign quad   = phase[PB-1 -: 2];
   assign qpos   = phase[QB-1:0];
   assign kpos   = quad[0] ? KW'(pwg_pkg::QUARTER_SIZE) - {1'b0, qpos} : {1'b0, qpos};
   assign qentry = kpos[QB] ? pwg_pkg::QSINE_PEAK : pwg_pkg::QSINE_TABLE[kpos[QB-1:0]];
   assign qfloor = qentry[7:0];
   assign qceil  = (qentry[15:8] > pwg_pkg::BIAS_VAL) ? pwg_pkg::BIAS_VAL : qentry[15:8];
   assign pos_sum = {1'b0, pwg_pkg::BIAS_VAL} + {1'b0, qfloor};

   always_comb begin
      if (!quad[1]) begin
         sine_v = pos_sum[SW] ? pwg_pkg::FULL_VAL : pos_sum[SW-1:0];
      end else begin
         sine_v = pwg_pkg::BIAS_VAL - qceil;
      end
   end

   // sample shaping per waveform
   always_comb begin
      unique case (waveform_ff)
         pwg_pkg::WAVE_SINE:   wave_v = sine_v;
         pwg_pkg::WAVE_SQUARE: wave_v = lower_ff ? pwg_pkg::FULL_VAL : '0;
         pwg_pkg::WAVE_TRIANGLE: begin
            if (lower_ff) begin
               wave_v = div_sts.quotient[SW-1:0] + pwg_pkg::BIAS_VAL;
            end else begin
               wave_v = pwg_pkg::FULL_VAL - div_sts.quotient[SW-1:0];
            end
         end
         default:              wave_v = div_sts.quotient[SW-1:0] + pwg_pkg::BIAS_VAL;
      endcase
   end

   assign last_now = (i_ff == n_ff - 1'b1);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      restart_in    = restart_ff;
      lower_in      = lower_ff;
      live_in       = live_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      sample_in     = sample_ff;
      period_end_in = period_end_ff;
      active_in     = active_ff;
      div_cmd       = '0;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               restart_in = req_bus.restart;
               live_in    = cfg_ok;
               if (cfg_ok) begin
                  div_cmd.start = 1'b1;
                  div_cmd.rem   = '0;
                  div_cmd.dvd   = sample_rate_ff;
                  div_cmd.dvsr  = RW'(tone_freq_ff);
                  div_cmd.steps = pwg_pkg::PERIOD_STEPS;
                  state_in      = ST_DIV_N;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_DIV_N: begin
            if (div_sts.done) begin
               n_in     = div_sts.quotient;
               state_in = ST_INDEX;
            end
         end
         ST_INDEX: begin
            i_in     = (restart_ff || idx_ff >= n_ff) ? '0 : idx_ff;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            lower_in = lower_now;
            unique case (waveform_ff)
               pwg_pkg::WAVE_SINE: begin
                  div_cmd.start = 1'b1;
                  div_cmd.rem   = i_ff >> 1;
                  div_cmd.dvd   = {i_ff[0], {(RW-1){1'b0}}};
                  div_cmd.dvsr  = n_ff;
                  div_cmd.steps = pwg_pkg::SINE_STEPS;
                  state_in      = ST_DIV_W;
               end
               pwg_pkg::WAVE_SQUARE: begin
                  state_in = ST_FINISH;
               end
               pwg_pkg::WAVE_TRIANGLE: begin
                  div_cmd.start = 1'b1;
                  div_cmd.rem   = ramp_x >> 1;
                  div_cmd.dvd   = {ramp_x[0], {(RW-1){1'b0}}};
                  div_cmd.dvsr  = half;
                  div_cmd.steps = pwg_pkg::RAMP_STEPS;
                  state_in      = ST_DIV_W;
               end
               default: begin
                  div_cmd.start = 1'b1;
                  div_cmd.rem   = i_ff >> 1;
                  div_cmd.dvd   = {i_ff[0], {(RW-1){1'b0}}};
                  div_cmd.dvsr  = n_ff;
                  div_cmd.steps = pwg_pkg::RAMP_STEPS;
                  state_in      = ST_DIV_W;
               end
            endcase
         end
         ST_DIV_W: begin
            if (div_sts.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               if (live_ff) begin
                  sample_in     = wave_v;
                  period_end_in = last_now;
                  active_in     = 1'b1;
                  idx_in        = last_now ? '0 : i_ff + 1'b1;
               end else begin
                  sample_in     = pwg_pkg::BIAS_VAL;
                  period_end_in = 1'b0;
                  active_in     = 1'b0;
                  idx_in        = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // any register write restarts the period
      if (cfg_hit) begin
         idx_in = '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         waveform_ff    <= '0;
         sample_rate_ff <= '0;
         tone_freq_ff   <= '0;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         waveform_ff    <= waveform_in;
         sample_rate_ff <= sample_rate_in;
         tone_freq_ff   <= tone_freq_in;
         idx_ff         <= idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      i_ff          <= i_in;
      restart_ff    <= restart_in;
      lower_ff      <= lower_in;
      live_ff       <= live_in;
      sample_ff     <= sample_in;
      period_end_ff <= period_end_in;
      active_ff     <= active_in;
   end

   // result channel
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.sample     = sample_ff;
   assign rsp_bus.period_end = period_end_ff;
   assign rsp_bus.active     = active_ff;

`ifndef SYNTHESIS
   // an inactive result is the idle level with no period end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !active_ff |-> sample_ff == pwg_pkg::BIAS_VAL && !period_end_ff)
      else $error("inactive result not at bias level");
   // divider completions only arrive while the sequencer waits for them
   assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> state_ff == ST_DIV_N || state_ff == ST_DIV_W)
      else $error("divider finished outside a divide step");
   // the last sample of a period sends the index back to the start
   assert property (@(posedge clock) disable iff (reset)
      load_out && live_ff && last_now |=> idx_ff == '0)
      else $error("sample index not wrapped at period end");
`endif

endmodule

// ===== src/pwg_divider.sv =====
// shared restoring divider, one quotient bit per cycle, for the period, phase and ramp divisions
// depends on pwg_pkg for the command and status structs
module pwg_divider (
   input  logic                clock,
   input  logic                reset,
   input  pwg_pkg::div_cmd_type cmd,
   output pwg_pkg::div_sts_type sts
);

   localparam int unsigned W = pwg_pkg::DIV_WIDTH;

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [pwg_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic [W-1:0]                    rem_ff, rem_in;
   logic [W-1:0]                    dvd_ff, dvd_in;
   logic [W-1:0]                    dvsr_ff, dvsr_in;
   logic [W-1:0]                    quot_ff, quot_in;

   logic [W:0] trial;
   logic [W:0] diff;
   logic       fits;

   // one trial subtraction per cycle
   assign trial = {rem_ff, dvd_ff[W-1]};
   assign diff  = trial - {1'b0, dvsr_ff};
   assign fits  = trial >= {1'b0, dvsr_ff};

   // sequencing of the steps
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      dvsr_in  = dvsr_ff;
      quot_in  = quot_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         count_in = cmd.steps;
         rem_in   = cmd.rem;
         dvd_in   = cmd.dvd;
         dvsr_in  = cmd.dvsr;
         quot_in  = '0;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[W-1:0] : trial[W-1:0];
         dvd_in   = {dvd_ff[W-2:0], 1'b0};
         quot_in  = {quot_ff[W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == pwg_pkg::COUNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dvsr_ff <= dvsr_in;
      quot_ff <= quot_in;
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quot_ff;

`ifndef SYNTHESIS
   // a running division always has steps left
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> count_ff != '0)
      else $error("divider busy with no steps left");
   // completion only once the steps have stopped
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while still busy");
   // a start always leads into a running division
   assert property (@(posedge clock) disable iff (reset) cmd.start |=> busy_ff)
      else $error("divider start not taken");
`endif

endmodule

// ===== tb/sv/periodic_waveform_generator_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for periodic_waveform_generator: apb set-up, tick driver and sample monitor
// depends on pwg_pkg, the channel interfaces in pwg_if and the block itself
module periodic_waveform_generator_test;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 64;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [pwg_pkg::SAMPLE_WIDTH-1:0] sample;
      logic                             period_end;
      logic                             active;
   } tone_sample_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [pwg_pkg::CSR_ADDR_WIDTH-1:0] paddr;
   logic [pwg_pkg::CSR_DATA_WIDTH-1:0] pwdata;
   logic [pwg_pkg::CSR_DATA_WIDTH-1:0] prdata;
   logic pready;

   pwg_req_if req_bus ();
   pwg_rsp_if rsp_bus ();

   periodic_waveform_generator uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // shadow of the registers and the tone state
   logic [pwg_pkg::WAVE_WIDTH-1:0] wave_sel;
   logic [pwg_pkg::RATE_WIDTH-1:0] rate_hz;
   logic [pwg_pkg::FREQ_WIDTH-1:0] freq_hz;
   logic [pwg_pkg::RATE_WIDTH-1:0] tick_index;
   logic [pwg_pkg::RATE_WIDTH-1:0] period_len;

   bit              pending_ticks[$];
   tone_sample_type expected_samples[$];
   bit              gaps_on;
   int              tick_gap;
   int              hold_off;
   int              failures;
   int              cycle_count;
   int              ticks_sent;
   int              results_checked;
   int              active_results;
   int              end_marks;
   int              settings_count;

   // (a*b) >> 60 kept to 64 bits
   function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] wide;
      wide = 128'(a) * 128'(b);
      return 64'(wide >> 60);
   endfunction

   // sin over one quarter wave, q60, by taylor series
   function automatic logic [63:0] quarter_wave(input int unsigned k);
      logic [63:0] angle;
      logic [63:0] angle_sq;
      logic [63:0] term;
      logic [63:0] acc;
      int unsigned j;
      angle    = q60_mul(pwg_pkg::HALF_PI_Q60, 64'(k) << (60 - pwg_pkg::QUARTER_BITS));
      angle_sq = q60_mul(angle, angle);
      term     = angle;
      acc      = angle;
      for (j = 1; j < 16; j++) begin
         term = q60_mul(term, angle_sq) / 64'((2 * j) * (2 * j + 1));
         acc  = (j % 2 == 1) ? acc - term : acc + term;
      end
      return acc;
   endfunction

   // floor of 128 + 128*sin, saturated at full scale
   function automatic logic [7:0] sine_level(input int unsigned i, input int unsigned n);
      int unsigned phase;
      int unsigned quad;
      int unsigned r;
      int unsigned k;
      logic [63:0] s;
      logic [63:0] lvl;
      phase = 32'((64'(i) << pwg_pkg::SINE_PHASE_BITS) / 64'(n));
      quad  = (phase >> pwg_pkg::QUARTER_BITS) & 3;
      r     = phase & (pwg_pkg::QUARTER_SIZE - 1);
      k     = (quad & 1) ? pwg_pkg::QUARTER_SIZE - r : r;
      s     = quarter_wave(k);
      if (quad < 2) begin
         lvl = 64'd128 + (s >> 53);
         if (lvl > 64'd255) lvl = 64'd255;
      end else begin
         lvl = (s + ((64'd1 << 53) - 64'd1)) >> 53;
         if (lvl > 64'd128) lvl = 64'd128;
         lvl = 64'd128 - lvl;
      end
      return lvl[7:0];
   endfunction

   // period from rate and frequency; zero marks unusable settings
   function automatic void retune();
      if (rate_hz < 2 * pwg_pkg::MIN_TONE_HZ || freq_hz < pwg_pkg::MIN_TONE_HZ ||
          freq_hz > rate_hz / 2) begin
         period_len = '0;
      end else begin
         period_len = rate_hz / freq_hz;
      end
      tick_index = '0;
   endfunction

   // expected sample for one tick, advancing the index
   function automatic tone_sample_type next_tone_sample(input logic restart);
      tone_sample_type res;
      int unsigned n;
      int unsigned i;
      int unsigned h;
      int unsigned v;
      n = 32'(period_len);
      if (n == 0) begin
         tick_index     = '0;
         res.sample     = pwg_pkg::BIAS_VAL;
         res.period_end = 1'b0;
         res.active     = 1'b0;
      end else begin
         if (restart || tick_index >= n) tick_index = '0;
         i = 32'(tick_index);
         h = n / 2;
         case (wave_sel)
            pwg_pkg::WAVE_SINE: begin
               v = 32'(sine_level(i, n));
            end
            pwg_pkg::WAVE_SQUARE: begin
               v = (i < h) ? 255 : 0;
            end
            pwg_pkg::WAVE_TRIANGLE: begin
               v = (i < h) ? 128 + (256 * i) / h : 255 - (256 * (i - h)) / h;
            end
            default: begin
               v = (256 * i) / n + 128;
            end
         endcase
         res.sample     = 8'(v);
         res.period_end = (i == n - 1);
         res.active     = 1'b1;
         tick_index     = (i + 1 >= n) ? '0 : pwg_pkg::RATE_WIDTH'(i + 1);
      end
      return res;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // tick driver: predicts on each transfer, then loads the next pending tick after its gap
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.restart <= 1'b0;
         tick_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_samples.push_back(next_tone_sample(req_bus.restart));
            ticks_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (tick_gap > 0) begin
               tick_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_ticks.size() > 0) begin
               req_bus.valid   <= 1'b1;
               req_bus.restart <= pending_ticks.pop_front();
               tick_gap = gaps_on ? int'($urandom_range(0, 5)) : 0;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // sample monitor: checks each transfer against the oldest expectation, then stalls at random
   always @(posedge clock) begin
      tone_sample_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_off = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_samples.size() == 0) begin
               $error("unexpected sample transfer: sample %0d period_end %0b active %0b",
                      rsp_bus.sample, rsp_bus.period_end, rsp_bus.active);
               failures++;
            end else begin
               want = expected_samples.pop_front();
               results_checked++;
               if (want.active) active_results++;
               if (want.period_end) end_marks++;
               if (rsp_bus.sample !== want.sample) begin
                  $error("sample: expected %0d, got %0d", want.sample, rsp_bus.sample);
                  failures++;
               end
               if (rsp_bus.period_end !== want.period_end) begin
                  $error("period_end: expected %0b, got %0b", want.period_end,
                         rsp_bus.period_end);
                  failures++;
               end
               if (rsp_bus.active !== want.active) begin
                  $error("active: expected %0b, got %0b", want.active, rsp_bus.active);
                  failures++;
               end
            end
            hold_off = gaps_on ? int'($urandom_range(0, 5)) : 0;
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // one apb transfer: setup, then access until pready
   task automatic apb_transfer(input logic wr, input logic [1:0] reg_sel,
                               input logic [31:0] data, output logic [31:0] rd);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // register write with shadow update and, for the mapped registers, read-back of the masked value
   task automatic csr_write(input logic [1:0] reg_sel, input logic [31:0] value);
      logic [31:0] ignored;
      logic [31:0] readback;
      logic [31:0] stored;
      apb_transfer(1'b1, reg_sel, value, ignored);
      case (reg_sel)
         pwg_pkg::REG_WAVEFORM:    wave_sel = value[pwg_pkg::WAVE_WIDTH-1:0];
         pwg_pkg::REG_SAMPLE_RATE: rate_hz  = value[pwg_pkg::RATE_WIDTH-1:0];
         pwg_pkg::REG_TONE_FREQ:   freq_hz  = value[pwg_pkg::FREQ_WIDTH-1:0];
         default: ;
      endcase
      if (reg_sel != REG_UNUSED) begin
         retune();
         stored = (reg_sel == pwg_pkg::REG_WAVEFORM) ? 32'(wave_sel) :
                  (reg_sel == pwg_pkg::REG_SAMPLE_RATE) ? 32'(rate_hz) : 32'(freq_hz);
         apb_transfer(1'b0, reg_sel, 32'd0, readback);
         if (readback !== stored) begin
            $error("register %0d read-back: expected %0d, got %0d", reg_sel, stored,
                   readback);
            failures++;
         end
      end
   endtask

   // full tone set-up; spare upper bits carry noise that the block must drop
   task automatic set_tone(input logic [1:0] wave, input int unsigned rate,
                           input int unsigned freq);
      csr_write(pwg_pkg::REG_WAVEFORM, ($urandom & ~32'h3) | 32'(wave));
      csr_write(pwg_pkg::REG_SAMPLE_RATE, ($urandom & ~32'h3FFFF) | (rate & 32'h3FFFF));
      csr_write(pwg_pkg::REG_TONE_FREQ, ($urandom & ~32'h1FFFF) | (freq & 32'h1FFFF));
      settings_count++;
   endtask

   // block until the pipe is empty: nothing pending, nothing on the bus, nothing owed;
   // sampled between edges so that the driver's and monitor's updates have settled
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_bus.valid || expected_samples.size() != 0);
   endtask

   task automatic play_ticks(input int count, input int restart_one_in);
      int c;
      for (c = 0; c < count; c++) begin
         pending_ticks.push_back($urandom_range(0, restart_one_in - 1) == 0);
      end
      wait_drained();
   endtask

   initial begin
      int phase_no;
      int kind;
      int span;
      int unsigned rate;
      int unsigned freq;
      reset           <= 1'b1;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      gaps_on = 1'b1;
      wave_sel   = '0;
      rate_hz    = '0;
      freq_hz    = '0;
      tick_index = '0;
      period_len = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // settings left at reset are unusable: held mid-level, inactive
      pending_ticks = '{1'b0, 1'b1};
      wait_drained();

      // sine with four samples per period: peak saturates, trough clamps to zero
      set_tone(pwg_pkg::WAVE_SINE, 48000, 12000);
      pending_ticks = '{1'b0, 1'b0, 1'b0, 1'b0};
      wait_drained();

      // shortest period at the lowest rate, then a restart
      set_tone(pwg_pkg::WAVE_SQUARE, 40, 20);
      pending_ticks = '{1'b0, 1'b0, 1'b1};
      wait_drained();

      // highest rate and frequency
      set_tone(pwg_pkg::WAVE_TRIANGLE, 262143, 131071);
      pending_ticks = '{1'b0, 1'b0};
      wait_drained();

      // saw with a restart mid-period
      set_tone(pwg_pkg::WAVE_SAW, 60, 20);
      pending_ticks = '{1'b0, 1'b1, 1'b0};
      wait_drained();

      // out-of-range settings: frequency too low, above half the rate, rate too low
      set_tone(pwg_pkg::WAVE_SQUARE, 48000, 19);
      pending_ticks = '{1'b0};
      wait_drained();
      set_tone(pwg_pkg::WAVE_SQUARE, 1000, 501);
      pending_ticks = '{1'b0};
      wait_drained();
      set_tone(pwg_pkg::WAVE_SQUARE, 39, 20);
      pending_ticks = '{1'b0};
      wait_drained();

      // longest period, then a write to an unmapped address that must not move the index
      set_tone(pwg_pkg::WAVE_SAW, 262143, 20);
      pending_ticks = '{1'b0, 1'b0};
      wait_drained();
      csr_write(REG_UNUSED, $urandom);
      pending_ticks = '{1'b0};
      wait_drained();

      // random phases, mostly short periods so that many periods complete
      for (phase_no = 0; phase_no < 20; phase_no++) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         kind    = $urandom_range(0, 9);
         case (kind)
            0: begin
               span = $urandom_range(0, 2);
               if (span == 0) begin
                  rate = $urandom_range(0, 39);
                  freq = $urandom_range(0, 131071);
               end else if (span == 1) begin
                  rate = $urandom_range(40, 262143);
                  freq = $urandom_range(0, 19);
               end else begin
                  rate = $urandom_range(40, 262141);
                  freq = $urandom_range(rate / 2 + 1, 131071);
               end
               set_tone(2'($urandom_range(0, 3)), rate, freq);
            end
            1: begin
               csr_write(pwg_pkg::REG_WAVEFORM, $urandom);
               settings_count++;
            end
            2: begin
               csr_write(REG_UNUSED, $urandom);
            end
            3: begin
               set_tone(2'($urandom_range(0, 3)), $urandom_range(200000, 262143),
                        $urandom_range(20, 60));
            end
            default: begin
               span = $urandom_range(2, 80);
               rate = $urandom_range(20 * span, 262143);
               set_tone(2'($urandom_range(0, 3)), rate, rate / span);
            end
         endcase
         play_ticks($urandom_range(40, 80), 16);
      end

      gaps_on = 1'b1;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d ticks over %0d tone settings, all four waveforms and unusable ones",
               ticks_sent, settings_count);
      $display("checked %0d samples: %0d while playing, %0d period ends",
               results_checked, active_results, end_marks);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== periodic_waveform_generator.f =====
src/pwg_pkg.sv
src/pwg_if.sv
src/pwg_divider.sv
src/periodic_waveform_generator.sv
tb/sv/periodic_waveform_generator_test.sv
